@@ sv/haptic_knob_target_tick_macros.svh @@
// Assertion macros for the haptic knob target tick block.
// Included by the RTL files that carry concurrent assertions; needs clk and rst_n in scope.
`ifndef HAPTIC_KNOB_TARGET_TICK_MACROS_SVH
`define HAPTIC_KNOB_TARGET_TICK_MACROS_SVH

// Same-cycle implication, disabled during reset
`define HTT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset
`define HTT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/htt_pkg.sv @@
// Package for the haptic knob target tick block: types, codes, constants, saturation helper.
// No dependencies.
`default_nettype none

package htt_pkg;

    localparam int FRAC_BITS_DEF = 16;

    // product of a signed 32-bit angle and an unsigned 24-bit scale
    localparam int PROD_W = 56;

    typedef logic [2:0] haptic_mode_t;
    localparam haptic_mode_t MODE_DISABLE = 3'd0;
    localparam haptic_mode_t MODE_INERTIA = 3'd1;
    localparam haptic_mode_t MODE_ENCODER = 3'd2;
    localparam haptic_mode_t MODE_SPRING  = 3'd3;
    localparam haptic_mode_t MODE_DAMPED  = 3'd4;
    localparam haptic_mode_t MODE_SPIN    = 3'd5;

    typedef logic [1:0] ctrl_kind_t;
    localparam ctrl_kind_t CTRL_TORQUE   = 2'd0;
    localparam ctrl_kind_t CTRL_VELOCITY = 2'd1;
    localparam ctrl_kind_t CTRL_ANGLE    = 2'd2;

    typedef logic [2:0] reg_index_t;
    localparam reg_index_t REG_HAPTIC_MODE = 3'd0;
    localparam reg_index_t REG_DETENT_STEP = 3'd1;
    localparam reg_index_t REG_DETENTS_RAD = 3'd2;
    localparam reg_index_t REG_LIMIT_LOW   = 3'd3;
    localparam reg_index_t REG_LIMIT_HIGH  = 3'd4;
    localparam reg_index_t REG_REPORT_EN   = 3'd5;
    localparam reg_index_t REG_REVERSE     = 3'd6;

    localparam logic ITEM_KIND_TICK  = 1'b0;
    localparam logic ITEM_KIND_ENTER = 1'b1;

    // torque caps, always Q16
    localparam logic [16:0] CAP_HALF     = 17'd32768;
    localparam logic [16:0] CAP_FIFTH    = 17'd13107;
    localparam logic [16:0] CAP_ONE_HALF = 17'd98304;

    localparam logic [1:0] STEP_NONE = 2'b00;
    localparam logic [1:0] STEP_UP   = 2'b01;
    localparam logic [1:0] STEP_DOWN = 2'b11;

    typedef struct packed {
        haptic_mode_t       haptic_mode;
        logic [18:0]        detent_step;
        logic [23:0]        detents_per_radian;
        logic signed [31:0] limit_low;
        logic signed [31:0] limit_high;
        logic               report_enable;
        logic               reverse_direction;
    } cfg_t;

    typedef struct packed {
        logic signed [31:0] target;
        ctrl_kind_t         control_kind;
        logic               motor_on;
        logic [16:0]        torque_cap;
        logic [1:0]         step_report;
    } res_t;

    function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
        logic signed [31:0] r;
        if (v > 34'sh0_7FFF_FFFF)
            r = 32'sh7FFF_FFFF;
        else if (v < -34'sh0_8000_0000)
            r = 32'sh8000_0000;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage

`default_nettype wire

@@ sv/htt_quant.sv @@
// Detent quantizer: angle * detents_per_radian rounded to a saturated 32-bit detent index,
// purely combinational. Depends on htt_pkg.
`default_nettype none

module htt_quant #(
    parameter int FRAC_BITS = htt_pkg::FRAC_BITS_DEF
) (
    input  wire signed [31:0]  angle,
    input  wire        [23:0]  detents_per_radian,
    input  wire                reverse_direction,
    output logic signed [31:0] pos
);
    import htt_pkg::*;

    localparam int SH = 2 * FRAC_BITS;
    localparam logic [PROD_W-1:0] HALF = PROD_W'(1) << (SH - 1);
    localparam logic [PROD_W-1:0] Q_MAX = PROD_W'(64'h8000_0000);

    logic signed [PROD_W-1:0] prod;
    logic        [PROD_W-1:0] mag;
    logic        [PROD_W-1:0] q;
    logic        [PROD_W-1:0] q_cl;
    logic signed [33:0]       s;

    // round magnitude half away from zero, clamp, restore sign
    always_comb
    begin
        prod = PROD_W'(angle) * PROD_W'($signed({1'b0, detents_per_radian}));
        mag  = prod[PROD_W-1] ? PROD_W'(-prod) : PROD_W'(prod);
        q    = (mag + HALF) >> SH;
        q_cl = (q > Q_MAX) ? Q_MAX : q;
        s    = prod[PROD_W-1] ? -$signed({1'b0, q_cl[32:0]}) : $signed({1'b0, q_cl[32:0]});
        if (reverse_direction)
            s = -s;
        pos = sat32(s);
    end

endmodule

`default_nettype wire

@@ sv/htt_ctrl.sv @@
// Knob mode state: target, control kind, drive enable, torque cap and tick history,
// with the per-item update logic. Depends on htt_pkg and the assertion macro header.
`default_nettype none
`include "haptic_knob_target_tick_macros.svh"

module htt_ctrl #(
    parameter int FRAC_BITS = htt_pkg::FRAC_BITS_DEF
) (
    input  wire                clk,
    input  wire                rst_n,
    input  wire                upd,
    input  wire                kind,
    input  wire signed [31:0]  angle,
    input  wire signed [31:0]  velocity,
    input  wire signed [31:0]  pos,
    input  wire htt_pkg::cfg_t cfg,
    output htt_pkg::res_t      res
);
    import htt_pkg::*;

    localparam logic signed [32:0] ONE_FX    = 33'(longint'(1) << FRAC_BITS);
    localparam logic signed [32:0] THRESH_FX = 33'(((longint'(3) << FRAC_BITS) + 5) / 10);
    localparam logic signed [31:0] PRESET_FX = 32'(((longint'(42) << FRAC_BITS) + 5) / 10);
    localparam logic signed [31:0] SPIN_FX   = 32'(longint'(20) << FRAC_BITS);

    logic signed [31:0] target_reg,   target_next;
    ctrl_kind_t         control_reg,  control_next;
    logic               enable_reg,   enable_next;
    logic        [16:0] torque_reg,   torque_next;
    logic signed [31:0] anchor_reg,   anchor_next;
    logic signed [31:0] prev_vel_reg, prev_vel_next;
    logic signed [31:0] prev_det_reg, prev_det_next;
    logic        [1:0]  step;

    logic signed [32:0] dv;
    logic signed [32:0] dv_abs;
    logic               vel_big;
    logic signed [33:0] d2;
    logic signed [33:0] step34;

    always_comb
    begin
        dv      = 33'(velocity) - 33'(prev_vel_reg);
        dv_abs  = dv[32] ? -dv : dv;
        vel_big = (33'(velocity) > ONE_FX) || (33'(velocity) < -ONE_FX);
        d2      = (34'(angle) - 34'(anchor_reg)) <<< 1;
        step34  = $signed({15'd0, cfg.detent_step});

        target_next   = target_reg;
        control_next  = control_reg;
        enable_next   = enable_reg;
        torque_next   = torque_reg;
        anchor_next   = anchor_reg;
        prev_vel_next = prev_vel_reg;
        prev_det_next = prev_det_reg;
        step          = STEP_NONE;

        if (kind != ITEM_KIND_TICK)
        begin
            anchor_next   = angle;
            prev_vel_next = velocity;
            case (cfg.haptic_mode)
                MODE_DISABLE:
                begin
                    enable_next = 1'b0;
                end
                MODE_INERTIA:
                begin
                    enable_next  = 1'b1;
                    torque_next  = CAP_HALF;
                    control_next = CTRL_VELOCITY;
                    target_next  = '0;
                end
                MODE_ENCODER:
                begin
                    enable_next  = 1'b1;
                    torque_next  = CAP_FIFTH;
                    control_next = CTRL_ANGLE;
                    target_next  = PRESET_FX;
                    anchor_next  = PRESET_FX;
                end
                MODE_SPRING:
                begin
                    enable_next  = 1'b1;
                    torque_next  = CAP_ONE_HALF;
                    control_next = CTRL_ANGLE;
                    target_next  = PRESET_FX;
                end
                MODE_DAMPED:
                begin
                    enable_next  = 1'b1;
                    torque_next  = CAP_ONE_HALF;
                    control_next = CTRL_VELOCITY;
                    target_next  = '0;
                end
                MODE_SPIN:
                begin
                    enable_next  = 1'b1;
                    torque_next  = CAP_ONE_HALF;
                    control_next = CTRL_VELOCITY;
                    target_next  = SPIN_FX;
                end
                default:
                begin
                end
            endcase
        end
        else
        begin
            case (cfg.haptic_mode)
                MODE_INERTIA:
                begin
                    if (vel_big)
                    begin
                        if (dv_abs > THRESH_FX)
                            target_next = velocity;
                    end
                    else
                        target_next = '0;
                    prev_vel_next = velocity;
                end
                MODE_ENCODER:
                begin
                    if (d2 > step34)
                    begin
                        target_next = sat32(34'(target_reg) + step34);
                        anchor_next = target_next;
                    end
                    else if (d2 < -step34)
                    begin
                        target_next = sat32(34'(target_reg) - step34);
                        anchor_next = target_next;
                    end
                end
                MODE_DAMPED:
                begin
                    if (cfg.limit_low != cfg.limit_high)
                    begin
                        if (angle > cfg.limit_high)
                        begin
                            control_next = CTRL_ANGLE;
                            target_next  = cfg.limit_high;
                        end
                        else if (angle < cfg.limit_low)
                        begin
                            control_next = CTRL_ANGLE;
                            target_next  = cfg.limit_low;
                        end
                        else
                        begin
                            control_next = CTRL_VELOCITY;
                            target_next  = '0;
                        end
                    end
                end
                default:
                begin
                end
            endcase

            if (cfg.report_enable)
            begin
                prev_det_next = pos;
                if (pos > prev_det_reg)
                    step = STEP_UP;
                else if (pos < prev_det_reg)
                    step = STEP_DOWN;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg   <= '0;
            control_reg  <= CTRL_TORQUE;
            enable_reg   <= 1'b0;
            torque_reg   <= '0;
            anchor_reg   <= '0;
            prev_vel_reg <= '0;
            prev_det_reg <= '0;
        end
        else if (upd)
        begin
            target_reg   <= target_next;
            control_reg  <= control_next;
            enable_reg   <= enable_next;
            torque_reg   <= torque_next;
            anchor_reg   <= anchor_next;
            prev_vel_reg <= prev_vel_next;
            prev_det_reg <= prev_det_next;
        end
    end

    assign res.target       = target_next;
    assign res.control_kind = control_next;
    assign res.motor_on     = enable_next;
    assign res.torque_cap   = torque_next;
    assign res.step_report  = step;

    `HTT_ASSERT_NOW(a_ctrl_code, 1'b1, control_reg != 2'd3, "illegal control kind")
    `HTT_ASSERT_NOW(a_torque_preset, 1'b1,
        torque_reg == 17'd0 || torque_reg == CAP_HALF || torque_reg == CAP_FIFTH ||
        torque_reg == CAP_ONE_HALF, "torque cap is not a preset")
    `HTT_ASSERT_NEXT(a_hold_state, !upd,
        $stable(target_reg) && $stable(anchor_reg) && $stable(prev_det_reg),
        "state moved without an item")

endmodule

`default_nettype wire

@@ sv/haptic_knob_target_tick.sv @@
// Top level of the haptic knob target tick block: config registers, input register, result
// register. Depends on htt_pkg, htt_quant, htt_ctrl and the assertion macro header.
`default_nettype none
`include "haptic_knob_target_tick_macros.svh"

// Haptic knob detent-mode controller. Each input item (tuser = kind, tdata = angle and
// velocity, signed fixed point with FRAC_BITS fraction bits) yields exactly one result item.
// A tick (kind 0) runs the configured knob mode: inertia follows velocity, encoder steps the
// target by one detent, damped clamps to the angle limits; it also quantizes the angle to a
// detent index and, if report_enable, reports a step of +1/-1 against the previous tick. An
// enter item (kind 1) loads the mode's preset target, control kind, drive enable and torque cap.
// Rate: one item per clock, sustained while the result side is ready. An accepted item sits in
// the input register; the whole update (angle * detents_per_radian multiply, rounding to a
// detent index, mode state update) is combinational from there, so its result is loaded into
// the result register and offered from it. Mode state changes as that result is loaded, so
// back-to-back items see each other's updates in order. Backpressure on the result side stalls
// the input register; the input side stays ready while the input register is empty or
// moving on.
// Config writes (cfg_we, cfg_index, cfg_wdata) take effect at once and must only be issued
// while no item is in flight. Index 7 is ignored.
module haptic_knob_target_tick #(
    parameter int FRAC_BITS = htt_pkg::FRAC_BITS_DEF
) (
    input  wire         clk,
    input  wire         rst_n,
    // input items
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [63:0] s_tdata,   // [31:0] angle, [63:32] velocity
    input  wire  [0:0]  s_tuser,   // [0] kind
    // result items
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [55:0] m_tdata,   // [31:0] target, [33:32] control_kind, [34] motor_on,
                                   // [51:35] torque_cap, [53:52] step_report, [55:54] zero
    // configuration
    input  wire         cfg_we,
    input  wire  [2:0]  cfg_index,
    input  wire  [31:0] cfg_wdata
);
    import htt_pkg::*;

    cfg_t cfg_reg;

    // input register
    logic               a_valid_reg;
    logic               a_kind_reg;
    logic signed [31:0] a_angle_reg;
    logic signed [31:0] a_vel_reg;
    // result register
    logic               out_valid_reg;
    res_t               out_reg;

    logic               out_free;
    logic               a_free;
    logic               a_adv;
    logic               in_acc;
    logic signed [31:0] pos;
    res_t               res;

    // ready chains back from the result register
    assign out_free = !out_valid_reg || m_tready;
    assign a_adv    = a_valid_reg && out_free;
    assign a_free   = !a_valid_reg || out_free;
    assign s_tready = a_free;
    assign in_acc   = s_tvalid && a_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.haptic_mode        <= MODE_DISABLE;
            cfg_reg.detent_step        <= 19'd17157;
            cfg_reg.detents_per_radian <= 24'd250330;
            cfg_reg.limit_low          <= 32'sd216269;
            cfg_reg.limit_high         <= 32'sd334234;
            cfg_reg.report_enable      <= 1'b1;
            cfg_reg.reverse_direction  <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_HAPTIC_MODE: cfg_reg.haptic_mode        <= cfg_wdata[2:0];
                REG_DETENT_STEP: cfg_reg.detent_step        <= cfg_wdata[18:0];
                REG_DETENTS_RAD: cfg_reg.detents_per_radian <= cfg_wdata[23:0];
                REG_LIMIT_LOW:   cfg_reg.limit_low          <= cfg_wdata;
                REG_LIMIT_HIGH:  cfg_reg.limit_high         <= cfg_wdata;
                REG_REPORT_EN:   cfg_reg.report_enable      <= cfg_wdata[0];
                REG_REVERSE:     cfg_reg.reverse_direction  <= cfg_wdata[0];
                default:
                begin
                end
            endcase
        end
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_free)
                a_valid_reg <= s_tvalid;
            if (out_free)
                out_valid_reg <= a_valid_reg;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            a_kind_reg  <= s_tuser[0];
            a_angle_reg <= s_tdata[31:0];
            a_vel_reg   <= s_tdata[63:32];
        end
        if (a_adv)
            out_reg <= res;
    end

    htt_quant #(
        .FRAC_BITS (FRAC_BITS)
    ) u_quant (
        .angle              (a_angle_reg),
        .detents_per_radian (cfg_reg.detents_per_radian),
        .reverse_direction  (cfg_reg.reverse_direction),
        .pos                (pos)
    );

    htt_ctrl #(
        .FRAC_BITS (FRAC_BITS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .upd      (a_adv),
        .kind     (a_kind_reg),
        .angle    (a_angle_reg),
        .velocity (a_vel_reg),
        .pos      (pos),
        .cfg      (cfg_reg),
        .res      (res)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_reg.step_report, out_reg.torque_cap, out_reg.motor_on,
                       out_reg.control_kind, out_reg.target};

    `HTT_ASSERT_NOW(a_step_code, m_tvalid, m_tdata[53:52] != 2'b10, "bad step report code")
    `HTT_ASSERT_NEXT(a_hold_out, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata),
        "result item changed under stall")
    `HTT_ASSERT_NEXT(a_hold_a, a_valid_reg && !out_free, a_valid_reg,
        "input register item dropped under stall")

endmodule

`default_nettype wire
